>>> hdl/heightmap_bilinear_sampler_macros.svh
// Assertion helpers used by the top module of the height map sampler.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define HBS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HBS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define HBS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons)
`define HBS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

>>> hdl/hbs_pkg.sv
`timescale 1ns / 1ps

package hbs_pkg;

  localparam int GRID_DIM  = 257;
  localparam int HEIGHT_W  = 24;
  localparam int RAM_DEPTH = GRID_DIM * GRID_DIM;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int IDX_W     = 9;
  localparam int COORD_W   = 17;
  localparam int POS_W     = 19;
  localparam int INV_W     = 16;

  // Shared multiplier: signed A by signed B, accumulated.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int ACC_W   = 42;
  localparam int SCALE_SHIFT = 12;

  localparam logic [INV_W-1:0] INV_RESET  = 16'd4096;
  localparam logic [IDX_W-1:0] USED_RESET = 9'd257;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_BOUNDS = 2'd2,
    OP_NOP    = 2'd3
  } hbs_op_t;

  typedef enum logic [1:0] {
    CFG_INV_CELL = 2'd0,
    CFG_COLS     = 2'd1,
    CFG_ROWS     = 2'd2,
    CFG_UNUSED   = 2'd3
  } hbs_cfg_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCALE_X,
    ST_SCALE_Z,
    ST_CLAMP_X,
    ST_CLAMP_Z,
    ST_READ00,
    ST_READ10,
    ST_READ01,
    ST_READ11,
    ST_ROW1,
    ST_ROW1B,
    ST_WAIT1,
    ST_BLEND0,
    ST_BLEND1,
    ST_WAIT2,
    ST_FINISH,
    ST_SCAN_RD,
    ST_SCAN_TAIL,
    ST_SCAN_DONE,
    ST_RESULT
  } hbs_state_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

  // A used size of zero counts as one, anything above the grid as the grid.
  function automatic logic [IDX_W-1:0] used_size(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = IDX_W'(1);
    end else if (v > IDX_W'(GRID_DIM)) begin
      r = IDX_W'(GRID_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> hdl/hbs_ram.sv
`timescale 1ns / 1ps

module hbs_ram #(
  parameter int DEPTH = 66049,
  parameter int WIDTH = 24,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/hbs_mac.sv
`timescale 1ns / 1ps

module hbs_mac import hbs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  mac_ctl_t                  ctl,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [MUL_A_W+MUL_B_W-1:0] prod;
  logic                              prod_vld;
  logic                              prod_clr;

  // Product is registered before it reaches the accumulator, so a result
  // reaches acc through the prod register and then the acc register.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      prod_clr <= 1'b0;
    end else begin
      prod_vld <= ctl.issue;
      prod_clr <= ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (prod_vld) begin
      if (prod_clr) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

endmodule

>>> hdl/heightmap_bilinear_sampler.sv
`timescale 1ns / 1ps

// Height map bilinear sampler.
// Input channel (in_valid / in_stall) carries one command beat: opcode 0 stores
// write_height at (write_col, write_row), opcode 1 samples at (sample_x,
// sample_z), opcode 2 scans the used grid for its lowest and highest heights.
// Each command gives exactly one result beat on the output channel
// (out_valid / out_stall) with result_kind echoing the opcode.
// Configuration (inv_cell_size, cols_in_use, rows_in_use) is written through
// cfg_valid / cfg_ready / cfg_index / cfg_data; the user is bound to write it
// only while the block is idle, and the block itself does not enforce this.
// One command is in flight at a time; in_stall stays high until its result
// beat is taken. A write passes through ST_WRITE, opcode 3 goes straight to
// the result, a sample does the four neighbor reads through the single port
// height memory plus the shared multiply-accumulate unit, which does the
// scaling and all bilinear products, and a bounds scan reads one grid entry
// per cycle. After reset the height memory is cleared one entry per cycle,
// all 66049 entries, with in_stall held high; configuration writes are taken
// meanwhile. A stalled result holds on the output ports until out_stall drops.

`include "heightmap_bilinear_sampler_macros.svh"

module heightmap_bilinear_sampler import hbs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 opcode,
  input  logic [IDX_W-1:0]           write_col,
  input  logic [IDX_W-1:0]           write_row,
  input  logic signed [HEIGHT_W-1:0] write_height,
  input  logic signed [POS_W-1:0]    sample_x,
  input  logic signed [POS_W-1:0]    sample_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 result_kind,
  output logic signed [HEIGHT_W-1:0] sampled_height,
  output logic signed [HEIGHT_W-1:0] bound_min,
  output logic signed [HEIGHT_W-1:0] bound_max,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [INV_W-1:0]           cfg_data
);

  hbs_state_t state, state_next;

  // Configuration registers.
  logic [INV_W-1:0] inv_cell_size;
  logic [IDX_W-1:0] cols_in_use;
  logic [IDX_W-1:0] rows_in_use;
  logic [IDX_W-1:0] cols_used;
  logic [IDX_W-1:0] rows_used;

  // Latched command.
  logic [IDX_W-1:0]           wcol_q;
  logic [IDX_W-1:0]           wrow_q;
  logic signed [HEIGHT_W-1:0] wh_q;
  logic signed [POS_W-1:0]    px_q;
  logic signed [POS_W-1:0]    pz_q;

  // Sample datapath.
  logic [COORD_W-1:0]         ux;
  logic [COORD_W-1:0]         uz;
  logic [COORD_W-1:0]         clamp_val;
  logic [IDX_W-1:0]           clamp_used;
  logic [ACC_W-SCALE_SHIFT-1:0] u_raw;
  logic [COORD_W-1:0]         u_lim;
  logic [IDX_W-1:0]           x0, z0, x1, z1;
  logic [7:0]                 tx, tz;
  logic signed [HEIGHT_W-1:0] h_hold;
  logic signed [MUL_A_W-1:0]  r0;

  // Scan datapath.
  logic [IDX_W-1:0]           scan_col;
  logic [IDX_W-1:0]           scan_row;
  logic [ADDR_W-1:0]          row_base;
  logic                       scan_vld;
  logic                       scan_first;
  logic                       scan_last;
  logic signed [HEIGHT_W-1:0] min_height;
  logic signed [HEIGHT_W-1:0] max_height;
  logic [ADDR_W-1:0]          clr_addr;

  // Result register.
  logic [1:0]                 res_kind;
  logic signed [HEIGHT_W-1:0] res_sample;
  logic signed [HEIGHT_W-1:0] res_min;
  logic signed [HEIGHT_W-1:0] res_max;

  // Memory and multiplier controls.
  logic                       ram_we;
  logic                       ram_re;
  logic [ADDR_W-1:0]          ram_addr;
  logic [HEIGHT_W-1:0]        ram_wdata;
  logic [HEIGHT_W-1:0]        ram_rdata;
  logic signed [HEIGHT_W-1:0] rd_h;
  mac_ctl_t                   mac_ctl;
  logic signed [MUL_A_W-1:0]  mac_a;
  logic signed [MUL_B_W-1:0]  mac_b;
  logic signed [ACC_W-1:0]    acc;

  logic in_fire;
  logic out_fire;
  logic write_ok;

  function automatic logic [ADDR_W-1:0] grid_addr(input logic [IDX_W-1:0] col,
                                                  input logic [IDX_W-1:0] row);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(row) * ADDR_W'(GRID_DIM) + ADDR_W'(col);
    return a;
  endfunction

  assign cfg_ready = 1'b1;
  assign cols_used = used_size(cols_in_use);
  assign rows_used = used_size(rows_in_use);

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign write_ok = (wcol_q < IDX_W'(GRID_DIM)) && (wrow_q < IDX_W'(GRID_DIM));

  assign rd_h = $signed(ram_rdata);

  // Clamp of a scaled coordinate; the multiplier result sits in acc.
  assign clamp_used = (state == ST_CLAMP_X) ? cols_used : rows_used;
  assign u_raw      = acc[ACC_W-1:SCALE_SHIFT];
  assign u_lim      = {clamp_used - IDX_W'(1), 8'd0};

  always_comb begin
    if (acc[ACC_W-1]) begin
      clamp_val = '0;
    end else if (u_raw > (ACC_W-SCALE_SHIFT)'(u_lim)) begin
      clamp_val = u_lim;
    end else begin
      clamp_val = u_raw[COORD_W-1:0];
    end
  end

  assign x0 = ux[COORD_W-1:8];
  assign z0 = uz[COORD_W-1:8];
  assign tx = ux[7:0];
  assign tz = uz[7:0];
  assign x1 = ((IDX_W+1)'(x0) + (IDX_W+1)'(1) < (IDX_W+1)'(cols_used)) ?
              x0 + IDX_W'(1) : cols_used - IDX_W'(1);
  assign z1 = ((IDX_W+1)'(z0) + (IDX_W+1)'(1) < (IDX_W+1)'(rows_used)) ?
              z0 + IDX_W'(1) : rows_used - IDX_W'(1);

  assign scan_last = (scan_col == cols_used - IDX_W'(1)) &&
                     (scan_row == rows_used - IDX_W'(1));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(RAM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (hbs_op_t'(opcode))
            OP_WRITE:  state_next = ST_WRITE;
            OP_SAMPLE: state_next = ST_SCALE_X;
            OP_BOUNDS: state_next = ST_SCAN_RD;
            OP_NOP:    state_next = ST_RESULT;
          endcase
        end
      end
      ST_WRITE:     state_next = ST_RESULT;
      ST_SCALE_X:   state_next = ST_SCALE_Z;
      ST_SCALE_Z:   state_next = ST_CLAMP_X;
      ST_CLAMP_X:   state_next = ST_CLAMP_Z;
      ST_CLAMP_Z:   state_next = ST_READ00;
      ST_READ00:    state_next = ST_READ10;
      ST_READ10:    state_next = ST_READ01;
      ST_READ01:    state_next = ST_READ11;
      ST_READ11:    state_next = ST_ROW1;
      ST_ROW1:      state_next = ST_ROW1B;
      ST_ROW1B:     state_next = ST_WAIT1;
      ST_WAIT1:     state_next = ST_BLEND0;
      ST_BLEND0:    state_next = ST_BLEND1;
      ST_BLEND1:    state_next = ST_WAIT2;
      ST_WAIT2:     state_next = ST_FINISH;
      ST_FINISH:    state_next = ST_RESULT;
      ST_SCAN_RD: begin
        if (scan_last) begin
          state_next = ST_SCAN_TAIL;
        end
      end
      ST_SCAN_TAIL: state_next = ST_SCAN_DONE;
      ST_SCAN_DONE: state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_fire) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshakes, memory port and multiplier operands.
  always_comb begin
    in_stall      = (state != ST_IDLE);
    out_valid     = (state == ST_RESULT);
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = '0;
    ram_wdata     = '0;
    mac_ctl.issue = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_a         = '0;
    mac_b         = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      ST_WRITE: begin
        ram_we    = write_ok;
        ram_addr  = grid_addr(wcol_q, wrow_q);
        ram_wdata = wh_q;
      end
      ST_SCALE_X: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = MUL_A_W'(px_q);
        mac_b         = MUL_B_W'(inv_cell_size);
      end
      ST_SCALE_Z: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = MUL_A_W'(pz_q);
        mac_b         = MUL_B_W'(inv_cell_size);
      end
      ST_READ00: begin
        ram_re   = 1'b1;
        ram_addr = grid_addr(x0, z0);
      end
      ST_READ10: begin
        ram_re        = 1'b1;
        ram_addr      = grid_addr(x1, z0);
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = MUL_A_W'(rd_h);
        mac_b         = MUL_B_W'(256) - MUL_B_W'(tx);
      end
      ST_READ01: begin
        ram_re        = 1'b1;
        ram_addr      = grid_addr(x0, z1);
        mac_ctl.issue = 1'b1;
        mac_a         = MUL_A_W'(rd_h);
        mac_b         = MUL_B_W'(tx);
      end
      ST_READ11: begin
        ram_re   = 1'b1;
        ram_addr = grid_addr(x1, z1);
      end
      ST_ROW1: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = MUL_A_W'(h_hold);
        mac_b         = MUL_B_W'(256) - MUL_B_W'(tx);
      end
      ST_ROW1B: begin
        mac_ctl.issue = 1'b1;
        mac_a         = MUL_A_W'(rd_h);
        mac_b         = MUL_B_W'(tx);
      end
      ST_BLEND0: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = acc[MUL_A_W-1:0];
        mac_b         = MUL_B_W'(tz);
      end
      ST_BLEND1: begin
        mac_ctl.issue = 1'b1;
        mac_a         = r0;
        mac_b         = MUL_B_W'(256) - MUL_B_W'(tz);
      end
      ST_SCAN_RD: begin
        ram_re   = 1'b1;
        ram_addr = row_base + ADDR_W'(scan_col);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell_size <= INV_RESET;
      cols_in_use   <= USED_RESET;
      rows_in_use   <= USED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (hbs_cfg_t'(cfg_index))
        CFG_INV_CELL: inv_cell_size <= cfg_data;
        CFG_COLS:     cols_in_use   <= cfg_data[IDX_W-1:0];
        CFG_ROWS:     rows_in_use   <= cfg_data[IDX_W-1:0];
        CFG_UNUSED: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      wcol_q <= write_col;
      wrow_q <= write_row;
      wh_q   <= write_height;
      px_q   <= sample_x;
      pz_q   <= sample_z;
    end
    if (state == ST_CLAMP_X) begin
      ux <= clamp_val;
    end
    if (state == ST_CLAMP_Z) begin
      uz <= clamp_val;
    end
    if (state == ST_READ11) begin
      h_hold <= rd_h;
    end
    // The first row blend is complete in acc when the second row starts.
    if (state == ST_ROW1) begin
      r0 <= acc[MUL_A_W-1:0];
    end
  end

  // Bounds scan: one entry read per cycle, compared the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld   <= 1'b0;
      scan_first <= 1'b0;
      scan_col   <= '0;
      scan_row   <= '0;
      row_base   <= '0;
      min_height <= '0;
      max_height <= '0;
    end else begin
      scan_vld <= (state == ST_SCAN_RD);
      if (in_fire) begin
        scan_first <= 1'b1;
        scan_col   <= '0;
        scan_row   <= '0;
        row_base   <= '0;
      end else if (state == ST_SCAN_RD) begin
        if (scan_col == cols_used - IDX_W'(1)) begin
          scan_col <= '0;
          scan_row <= scan_row + IDX_W'(1);
          row_base <= row_base + ADDR_W'(GRID_DIM);
        end else begin
          scan_col <= scan_col + IDX_W'(1);
        end
      end
      if (scan_vld) begin
        scan_first <= 1'b0;
        if (scan_first || (rd_h < min_height)) begin
          min_height <= rd_h;
        end
        if (scan_first || (rd_h > max_height)) begin
          max_height <= rd_h;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_kind   <= opcode;
      res_sample <= '0;
      res_min    <= '0;
      res_max    <= '0;
    end else begin
      // The blend sum divided by 65536 with floor is an arithmetic shift.
      if (state == ST_FINISH) begin
        res_sample <= acc[HEIGHT_W+15:16];
      end
      if (state == ST_SCAN_DONE) begin
        res_min <= min_height;
        res_max <= max_height;
      end
    end
  end

  assign result_kind    = res_kind;
  assign sampled_height = res_sample;
  assign bound_min      = res_min;
  assign bound_max      = res_max;

  hbs_ram #(
    .DEPTH (RAM_DEPTH),
    .WIDTH (HEIGHT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  hbs_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  `HBS_ASSERT_NEXT(a_one_in_flight, clk, rst, in_fire, in_stall)
  `HBS_ASSERT_NOW(a_no_accept_with_result, clk, rst, out_valid, in_stall)
  `HBS_ASSERT_NOW(a_index_in_grid, clk, rst, state == ST_READ00,
                  (x0 < cols_used) && (z0 < rows_used) && (x1 < cols_used) && (z1 < rows_used))
  `HBS_ASSERT_NOW(a_sample_only_on_sample, clk, rst,
                  out_valid && (result_kind != OP_SAMPLE), sampled_height == '0)

endmodule

>>> verif/hbs_checker.sv
`timescale 1ns / 1ps

module hbs_checker import hbs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 opcode,
  input  logic [IDX_W-1:0]           write_col,
  input  logic [IDX_W-1:0]           write_row,
  input  logic signed [HEIGHT_W-1:0] write_height,
  input  logic signed [POS_W-1:0]    sample_x,
  input  logic signed [POS_W-1:0]    sample_z,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 result_kind,
  input  logic signed [HEIGHT_W-1:0] sampled_height,
  input  logic signed [HEIGHT_W-1:0] bound_min,
  input  logic signed [HEIGHT_W-1:0] bound_max,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [INV_W-1:0]           cfg_data,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [HEIGHT_W-1:0] height;
    logic signed [HEIGHT_W-1:0] lo;
    logic signed [HEIGHT_W-1:0] hi;
  } outcome_t;

  logic signed [HEIGHT_W-1:0] grid_mem [RAM_DEPTH];
  logic [INV_W-1:0]           inv_cell;
  logic [IDX_W-1:0]           cols_cfg;
  logic [IDX_W-1:0]           rows_cfg;
  outcome_t                   awaited [$];

  function automatic int span(input logic [IDX_W-1:0] v);
    if (v == '0) return 1;
    if (v > IDX_W'(GRID_DIM)) return GRID_DIM;
    return int'(v);
  endfunction

  // Position times the inverse cell size, floored to Q.8 grid units and
  // clamped to the used part of the grid.
  function automatic longint grid_coord(input logic signed [POS_W-1:0] pos, input int used);
    longint scaled;
    longint limit;
    scaled = longint'(pos) * longint'(inv_cell);
    limit = longint'(used - 1) << 8;
    if (scaled < 0) return 0;
    scaled = scaled >>> SCALE_SHIFT;
    return (scaled > limit) ? limit : scaled;
  endfunction

  function automatic longint cell_h(input int col, input int row);
    return longint'(grid_mem[row * GRID_DIM + col]);
  endfunction

  function automatic outcome_t apply_command(
    input hbs_op_t                    op,
    input logic [IDX_W-1:0]           col,
    input logic [IDX_W-1:0]           row,
    input logic signed [HEIGHT_W-1:0] h,
    input logic signed [POS_W-1:0]    x,
    input logic signed [POS_W-1:0]    z
  );
    outcome_t                   res;
    int                         cols, rows, x0, z0, x1, z1;
    longint                     ux, uz, tx, tz, acc;
    logic signed [HEIGHT_W-1:0] lo, hi;
    res = '0;
    res.kind = op;
    cols = span(cols_cfg);
    rows = span(rows_cfg);
    case (op)
      OP_WRITE: begin
        if (col < GRID_DIM && row < GRID_DIM) grid_mem[int'(row) * GRID_DIM + int'(col)] = h;
      end
      OP_SAMPLE: begin
        ux = grid_coord(x, cols);
        uz = grid_coord(z, rows);
        x0 = int'(ux >>> 8);
        z0 = int'(uz >>> 8);
        tx = ux & 255;
        tz = uz & 255;
        x1 = (x0 + 1 < cols) ? x0 + 1 : cols - 1;
        z1 = (z0 + 1 < rows) ? z0 + 1 : rows - 1;
        acc = (256 - tx) * (256 - tz) * cell_h(x0, z0)
            + tx * (256 - tz) * cell_h(x1, z0)
            + (256 - tx) * tz * cell_h(x0, z1)
            + tx * tz * cell_h(x1, z1);
        // Arithmetic shift floors toward minus infinity.
        res.height = HEIGHT_W'(acc >>> 16);
      end
      OP_BOUNDS: begin
        lo = grid_mem[0];
        hi = grid_mem[0];
        for (int r = 0; r < rows; r++) begin
          for (int c = 0; c < cols; c++) begin
            if (grid_mem[r * GRID_DIM + c] < lo) lo = grid_mem[r * GRID_DIM + c];
            if (grid_mem[r * GRID_DIM + c] > hi) hi = grid_mem[r * GRID_DIM + c];
          end
        end
        res.lo = lo;
        res.hi = hi;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      foreach (grid_mem[i]) grid_mem[i] = '0;
      inv_cell = INV_RESET;
      cols_cfg = USED_RESET;
      rows_cfg = USED_RESET;
      awaited.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (hbs_cfg_t'(cfg_index))
          CFG_INV_CELL: inv_cell = cfg_data;
          CFG_COLS:     cols_cfg = cfg_data[IDX_W-1:0];
          CFG_ROWS:     rows_cfg = cfg_data[IDX_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $error("result beat with no command waiting");
          mismatches++;
        end else begin
          want = awaited.pop_front();
          check_field("result_kind", longint'(want.kind), longint'(result_kind));
          check_field("sampled_height", longint'($signed(want.height)),
                      longint'(sampled_height));
          check_field("bound_min", longint'($signed(want.lo)), longint'(bound_min));
          check_field("bound_max", longint'($signed(want.hi)), longint'(bound_max));
        end
      end
      if (in_valid && !in_stall) begin
        awaited.push_back(apply_command(hbs_op_t'(opcode), write_col, write_row,
                                        write_height, sample_x, sample_z));
      end
    end
    outstanding <= awaited.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import hbs_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 74;
  localparam logic signed [HEIGHT_W-1:0] H_MAX = {1'b0, {(HEIGHT_W-1){1'b1}}};
  localparam logic signed [HEIGHT_W-1:0] H_MIN = {1'b1, {(HEIGHT_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0]    P_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]    P_MIN = {1'b1, {(POS_W-1){1'b0}}};

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 opcode;
  logic [IDX_W-1:0]           write_col;
  logic [IDX_W-1:0]           write_row;
  logic signed [HEIGHT_W-1:0] write_height;
  logic signed [POS_W-1:0]    sample_x;
  logic signed [POS_W-1:0]    sample_z;
  logic                       out_valid;
  logic                       out_stall;
  logic [1:0]                 result_kind;
  logic signed [HEIGHT_W-1:0] sampled_height;
  logic signed [HEIGHT_W-1:0] bound_min;
  logic signed [HEIGHT_W-1:0] bound_max;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index;
  logic [INV_W-1:0]           cfg_data;

  int               mismatches;
  int               outstanding;
  int               cycles = 0;
  logic             quiet;
  logic             long_hold;
  logic [INV_W-1:0] cur_inv;
  int               cur_cols;
  int               cur_rows;

  heightmap_bilinear_sampler u_dut (.*);

  hbs_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: short random stalls, free stretches, and one long hold
  // that backs the block up while commands keep coming.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  task automatic issue(
    input hbs_op_t                    op,
    input logic [IDX_W-1:0]           col,
    input logic [IDX_W-1:0]           row,
    input logic signed [HEIGHT_W-1:0] h,
    input logic signed [POS_W-1:0]    x,
    input logic signed [POS_W-1:0]    z
  );
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    write_col    <= col;
    write_row    <= row;
    write_height <= h;
    sample_x     <= x;
    sample_z     <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input hbs_cfg_t idx, input logic [INV_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Aim most samples at the used grid, a little beyond each edge.
  function automatic logic signed [POS_W-1:0] pick_position(input int span_n);
    longint u;
    longint p;
    if (cur_inv == '0 || $urandom_range(0, 4) == 0) return POS_W'($urandom);
    u = longint'($urandom_range(0, (span_n - 1) * 256 + 600)) - 300;
    p = u * 4096 / longint'(cur_inv) + longint'($urandom_range(0, 3));
    if (p > longint'(P_MAX)) p = longint'(P_MAX);
    if (p < longint'(P_MIN)) p = longint'(P_MIN);
    return POS_W'(p);
  endfunction

  task automatic random_command();
    int                         pick;
    logic [IDX_W-1:0]           col;
    logic [IDX_W-1:0]           row;
    logic signed [HEIGHT_W-1:0] h;
    pick = $urandom_range(0, 99);
    col = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
                                      : IDX_W'($urandom_range(0, cur_cols - 1));
    row = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
                                      : IDX_W'($urandom_range(0, cur_rows - 1));
    case ($urandom_range(0, 5))
      0:       h = H_MAX;
      1:       h = H_MIN;
      2:       h = HEIGHT_W'($urandom_range(0, 4000)) - HEIGHT_W'(2000);
      default: h = HEIGHT_W'($urandom);
    endcase
    // Scans of a large grid are slow, so they become samples there.
    if (pick < 40) begin
      issue(OP_WRITE, col, row, h, POS_W'($urandom), POS_W'($urandom));
    end else if (pick < 88 || (pick < 96 && cur_cols * cur_rows > 1024)) begin
      issue(OP_SAMPLE, col, row, h, pick_position(cur_cols), pick_position(cur_rows));
    end else if (pick < 96) begin
      issue(OP_BOUNDS, col, row, h, POS_W'($urandom), POS_W'($urandom));
    end else begin
      issue(OP_NOP, col, row, h, POS_W'($urandom), POS_W'($urandom));
    end
  endtask

  task automatic run_phase(
    input logic [INV_W-1:0] inv,
    input logic [IDX_W-1:0] cols_raw,
    input logic [IDX_W-1:0] rows_raw,
    input logic             hold
  );
    settle();
    write_reg(CFG_INV_CELL, inv);
    write_reg(CFG_COLS, {7'($urandom), cols_raw});
    write_reg(CFG_ROWS, {7'($urandom), rows_raw});
    write_reg(CFG_UNUSED, INV_W'($urandom));
    cfg_valid <= 1'b0;
    cur_inv  = inv;
    cur_cols = (cols_raw == '0) ? 1 : (cols_raw > GRID_DIM) ? GRID_DIM : int'(cols_raw);
    cur_rows = (rows_raw == '0) ? 1 : (rows_raw > GRID_DIM) ? GRID_DIM : int'(rows_raw);
    if (hold) long_hold = 1'b1;
    repeat (PHASE_ITEMS) random_command();
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_WRITE;
    write_col    = '0;
    write_row    = '0;
    write_height = '0;
    sample_x     = '0;
    sample_z     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_INV_CELL;
    cfg_data     = '0;
    quiet        = 1'b0;
    long_hold    = 1'b0;
    cur_inv      = INV_RESET;
    cur_cols     = GRID_DIM;
    cur_rows     = GRID_DIM;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Full grid at reset settings, where one position unit is one Q9.8 grid step.
    issue(OP_BOUNDS, 0, 0, 0, 0, 0);
    issue(OP_WRITE, 0, 0, H_MAX, 0, 0);
    issue(OP_WRITE, 256, 256, H_MIN, 0, 0);
    issue(OP_WRITE, 1, 0, -1, 0, 0);
    issue(OP_WRITE, 0, 1, 24'h555555, 0, 0);
    issue(OP_WRITE, 1, 1, 24'hAAAAAA, 0, 0);
    issue(OP_WRITE, 256, 0, 100, 0, 0);
    // Writes off the grid must leave the store alone.
    issue(OP_WRITE, 511, 3, H_MAX, 0, 0);
    issue(OP_WRITE, 3, 257, H_MIN, 0, 0);
    issue(OP_SAMPLE, 0, 0, 0, 0, 0);
    issue(OP_SAMPLE, 0, 0, 0, 128, 128);
    issue(OP_SAMPLE, 0, 0, 0, P_MIN, P_MIN);
    issue(OP_SAMPLE, 0, 0, 0, P_MAX, P_MAX);
    issue(OP_SAMPLE, 0, 0, 0, 255, 1);
    issue(OP_SAMPLE, 0, 0, 0, 65535, 0);
    issue(OP_SAMPLE, 0, 0, 0, 65480, 65500);
    issue(OP_NOP, 9'h1FF, 9'h1FF, H_MIN, P_MIN, P_MAX);
    issue(OP_BOUNDS, 0, 0, 0, 0, 0);

    run_phase(16'hFFFF, 9'd2, 9'd2, 1'b0);
    run_phase(16'h0000, 9'd5, 9'd7, 1'b0);
    run_phase(16'd1, 9'd257, 9'd2, 1'b0);
    // Zero and oversized counts fall back to one and to the full grid.
    run_phase(16'd3000, 9'd0, 9'd511, 1'b0);
    run_phase(16'd2048, 9'd300, 9'd3, 1'b0);
    run_phase(INV_W'($urandom_range(512, 16384)), IDX_W'($urandom_range(2, 24)),
              IDX_W'($urandom_range(2, 24)), 1'b1);
    run_phase(INV_W'($urandom_range(1, 65535)), IDX_W'($urandom_range(2, 24)),
              IDX_W'($urandom_range(2, 24)), 1'b0);
    run_phase(INV_W'($urandom_range(512, 16384)), IDX_W'($urandom_range(2, 24)),
              IDX_W'($urandom_range(2, 24)), 1'b0);
    run_phase(INV_W'($urandom_range(512, 16384)), IDX_W'($urandom_range(2, 24)),
              IDX_W'($urandom_range(2, 24)), 1'b0);
    quiet = 1'b1;
    run_phase(INV_W'($urandom_range(512, 16384)), IDX_W'($urandom_range(2, 24)),
              IDX_W'($urandom_range(2, 24)), 1'b0);

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
